[rtl/core/buzzer_pattern_sequencer_macros.svh]
// assertion macros for the buzzer pattern sequencer
// plain text, no dependencies; included by the top level only
`ifndef BUZZER_PATTERN_SEQUENCER_MACROS_SVH
`define BUZZER_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bps_pkg.sv]
// shared types, constants and helpers of the buzzer pattern sequencer
// no dependencies; used by bps_divider and the top level module
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  // field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DUR_W    = 24;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned VOL_W    = 8;
  localparam int unsigned VLIST_W  = 64;
  localparam int unsigned RUN_W    = 24;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ACTION_W = 2;

  // parameter defaults
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned MAX_VOLUMES_DEF = 8;
  localparam int unsigned TICK_MS_DEF     = 10;

  // action codes carried on tuser
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_DEFAULT = 2'd3;

  // entry modes
  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd2;

  // input beat payload, mode in the lowest bits
  typedef struct packed {
    logic                mute;
    logic [COUNT_W-1:0]  volume_count;
    logic [VLIST_W-1:0]  volume_list;
    logic                forever_req;
    logic [DUR_W-1:0]    duration;
    logic [PERIOD_W-1:0] step_period;
    logic [MODE_W-1:0]   mode;
  } in_data_t;

  // output beat payload, volume in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    logic             push_rejected;
    logic             queue_empty;
    logic [VOL_W-1:0] volume;
  } out_data_t;

  // normalized control part of one tone entry
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] period;
    logic [DUR_W-1:0]    duration;
    logic                forever_req;
    logic [COUNT_W-1:0]  count;
  } ctl_t;

  // status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam ctl_t CTL_RESET = '{
    mode:        MODE_OFF,
    period:      PERIOD_W'(1),
    duration:    '0,
    forever_req: 1'b1,
    count:       COUNT_W'(1)
  };

  // clean up a raw entry: unknown mode is off, zero period is one,
  // volume count forced into one..max_count
  function automatic ctl_t make_ctl(in_data_t d, logic [COUNT_W-1:0] max_count);
    ctl_t c;
    c.mode        = (d.mode == MODE_ON || d.mode == MODE_PATTERN) ? d.mode : MODE_OFF;
    c.period      = (d.step_period == '0) ? PERIOD_W'(1) : d.step_period;
    c.duration    = d.duration;
    c.forever_req = d.forever_req;
    if (d.volume_count == '0) begin
      c.count = COUNT_W'(1);
    end else if (d.volume_count > max_count) begin
      c.count = max_count;
    end else begin
      c.count = d.volume_count;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bps_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies; holds the tone entry queue
`timescale 1ns / 1ps
`default_nettype none

module bps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/bps_divider.sv]
// bit-serial restoring divider: elapsed / period, quotient folded modulo count
// depends on bps_pkg; one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bps_divider #(
  parameter int unsigned DVD_W = 34
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [DVD_W-1:0]              dividend_i,
  input  wire logic [bps_pkg::PERIOD_W-1:0]  divisor_i,
  input  wire logic [bps_pkg::COUNT_W-1:0]   count_i,
  output bps_pkg::div_stat_t                 stat_o,
  output logic      [bps_pkg::IDX_W-1:0]     index_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam int unsigned PW    = bps_pkg::PERIOD_W;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0]    dvd_q, dvd_d;
  logic [PW-1:0]       rem_q, rem_d;
  logic [bps_pkg::IDX_W-1:0] mod_q, mod_d;

  logic [PW:0]                 trial;
  logic [PW:0]                 trial_sub;
  logic                        qbit;
  logic [bps_pkg::COUNT_W-1:0] mod_shift;

  // one restoring step plus the running remainder of the quotient modulo count
  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    trial_sub = trial - {1'b0, divisor_i};
    qbit      = (trial >= {1'b0, divisor_i});
    mod_shift = {mod_q, qbit};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    mod_d  = mod_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      mod_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? trial_sub[PW-1:0] : trial[PW-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      mod_d = (mod_shift >= count_i) ? bps_pkg::IDX_W'(mod_shift - count_i)
                                     : bps_pkg::IDX_W'(mod_shift);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign index_o     = mod_q;

endmodule

`default_nettype wire

[rtl/core/buzzer_pattern_sequencer.sv]
// buzzer pattern sequencer: tone entry queue, run counter and volume sequencer
// depends on bps_pkg, bps_ram, bps_divider and buzzer_pattern_sequencer_macros.svh
//
// usage:
//   s_axis carries one command beat: tuser is the action (tick, push entry,
//   flush queue, set default entry), tdata the entry fields and the mute level.
//   m_axis returns exactly one result beat per command: volume, queue_empty
//   and push_rejected. cfg_* writes the one-bit enable register, always ready.
// timing:
//   a tick passes the states mul, chk, rd, load and div, then done; the
//   bit-serial divider for elapsed / period works one quotient bit a cycle.
//   push, flush and set default go from idle straight to done. the result is
//   registered, and the next command is taken back in idle. s_axis_tready
//   is low in work.
// reset:
//   queue empty, run counter and held volume zero, default entry off and
//   forever, enable set. no clearing pass is needed.
// stalls:
//   the result sits in an output register; one further command is taken while
//   it waits, and that command's result waits in turn until m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "buzzer_pattern_sequencer_macros.svh"

module buzzer_pattern_sequencer #(
  parameter int unsigned QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_VOLUMES = bps_pkg::MAX_VOLUMES_DEF,
  parameter int unsigned TICK_MS     = bps_pkg::TICK_MS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // command beat
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // mode, step_period, duration, forever_req, volume_list, volume_count, mute
  input  wire logic [111:0]  s_axis_tdata,
  // action
  input  wire logic [1:0]    s_axis_tuser,
  // result beat
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // volume, queue_empty, push_rejected, zero pad
  output logic [15:0]        m_axis_tdata,
  // enable register write
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_data_i
);

  localparam int unsigned AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned VOLS_W = MAX_VOLUMES * bps_pkg::VOL_W;
  localparam int unsigned CTL_W  = $bits(bps_pkg::ctl_t);
  localparam int unsigned ENT_W  = CTL_W + VOLS_W;
  localparam int unsigned DVD_W  = bps_pkg::RUN_W + $clog2(TICK_MS + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [bps_pkg::RUN_W-1:0]   run_q, run_d;
  logic [DVD_W-1:0]            elapsed_q, elapsed_d;
  logic [AW-1:0]               head_q, head_d;
  logic [AW-1:0]               tail_q, tail_d;
  logic [OCC_W-1:0]            occ_q, occ_d;
  bps_pkg::ctl_t               dflt_ctl_q, dflt_ctl_d;
  logic [VOLS_W-1:0]           dflt_vol_q, dflt_vol_d;
  logic [bps_pkg::VOL_W-1:0]   last_vol_q, last_vol_d;
  logic                        enable_q;
  logic                        mute_q, mute_d;
  logic                        rej_q, rej_d;
  bps_pkg::ctl_t               cur_ctl_q, cur_ctl_d;
  logic [VOLS_W-1:0]           cur_vol_q, cur_vol_d;
  logic                        out_valid_q, out_valid_d;
  bps_pkg::out_data_t          out_data_q, out_data_d;

  bps_pkg::in_data_t           in_data;
  bps_pkg::ctl_t               in_ctl;
  bps_pkg::ctl_t               ram_ctl;
  bps_pkg::ctl_t               chk_ctl;
  logic [ENT_W-1:0]            ram_rdata;
  logic                        in_fire;
  logic                        full;
  logic                        ram_we;
  logic                        div_start;
  bps_pkg::div_stat_t          div_stat;
  logic [bps_pkg::IDX_W-1:0]   div_index;
  logic [bps_pkg::VOL_W-1:0]   pat_vol;
  logic [bps_pkg::VOL_W-1:0]   tick_vol;
  logic [AW-1:0]               head_inc;
  logic [AW-1:0]               tail_inc;

  assign in_data = bps_pkg::in_data_t'(s_axis_tdata);
  assign in_ctl  = bps_pkg::make_ctl(in_data, bps_pkg::COUNT_W'(MAX_VOLUMES));
  assign ram_ctl = bps_pkg::ctl_t'(ram_rdata[CTL_W-1:0]);
  assign full    = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign ram_we  = in_fire && (s_axis_tuser == bps_pkg::ACT_PUSH) && !full;
  assign div_start = (state_q == ST_LOAD);

  assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  // entry that governs the expiry check
  assign chk_ctl = (occ_q != '0) ? ram_ctl : dflt_ctl_q;

  // queue storage, read port follows the head
  bps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({in_data.volume_list[VOLS_W-1:0], in_ctl}),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // shared divider for the pattern step index
  bps_divider #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed_q),
    .divisor_i  (cur_ctl_q.period),
    .count_i    (cur_ctl_q.count),
    .stat_o     (div_stat),
    .index_o    (div_index)
  );

  // pattern volume select
  always_comb begin
    pat_vol = '0;
    for (int i = 0; i < int'(MAX_VOLUMES); i++) begin
      if (div_index == bps_pkg::IDX_W'(i)) begin
        pat_vol = cur_vol_q[i*bps_pkg::VOL_W +: bps_pkg::VOL_W];
      end
    end
  end

  // tick volume with mode, enable and mute applied
  always_comb begin
    unique case (cur_ctl_q.mode)
      bps_pkg::MODE_ON:      tick_vol = cur_vol_q[bps_pkg::VOL_W-1:0];
      bps_pkg::MODE_PATTERN: tick_vol = pat_vol;
      default:               tick_vol = '0;
    endcase
    if (!enable_q || mute_q) begin
      tick_vol = '0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    elapsed_d   = elapsed_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    dflt_ctl_d  = dflt_ctl_q;
    dflt_vol_d  = dflt_vol_q;
    last_vol_d  = last_vol_q;
    mute_d      = mute_q;
    rej_d       = rej_q;
    cur_ctl_d   = cur_ctl_q;
    cur_vol_d   = cur_vol_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rej_d = 1'b0;
          unique case (s_axis_tuser)
            bps_pkg::ACT_TICK: begin
              run_d   = (run_q == '1) ? run_q : run_q + 1'b1;
              mute_d  = in_data.mute;
              state_d = ST_MUL;
            end
            bps_pkg::ACT_PUSH: begin
              if (full) begin
                rej_d = 1'b1;
              end else begin
                tail_d = tail_inc;
                occ_d  = occ_q + 1'b1;
              end
              state_d = ST_DONE;
            end
            bps_pkg::ACT_FLUSH: begin
              head_d  = '0;
              tail_d  = '0;
              occ_d   = '0;
              state_d = ST_DONE;
            end
            default: begin
              dflt_ctl_d = in_ctl;
              dflt_vol_d = in_data.volume_list[VOLS_W-1:0];
              state_d    = ST_DONE;
            end
          endcase
        end
      end
      ST_MUL: begin
        elapsed_d = DVD_W'(run_q) * DVD_W'(TICK_MS);
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        // a finite entry that has run its time is retired
        if (!chk_ctl.forever_req && (elapsed_q >= DVD_W'(chk_ctl.duration))) begin
          if (occ_q != '0) begin
            head_d = head_inc;
            occ_d  = occ_q - 1'b1;
          end
          run_d = '0;
        end
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (occ_q != '0) begin
          cur_ctl_d = ram_ctl;
          cur_vol_d = ram_rdata[ENT_W-1:CTL_W];
        end else begin
          cur_ctl_d = dflt_ctl_q;
          cur_vol_d = dflt_vol_q;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          last_vol_d = tick_vol;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d              = 1'b1;
          out_data_d.pad           = '0;
          out_data_d.volume        = last_vol_q;
          out_data_d.queue_empty   = (occ_q == '0);
          out_data_d.push_rejected = rej_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      dflt_ctl_q  <= bps_pkg::CTL_RESET;
      dflt_vol_q  <= '0;
      last_vol_q  <= '0;
      enable_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      dflt_ctl_q  <= dflt_ctl_d;
      dflt_vol_q  <= dflt_vol_d;
      last_vol_q  <= last_vol_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    elapsed_q  <= elapsed_d;
    mute_q     <= mute_d;
    rej_q      <= rej_d;
    cur_ctl_q  <= cur_ctl_d;
    cur_vol_q  <= cur_vol_d;
    out_data_q <= out_data_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `BPS_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= OCC_W'(QUEUE_DEPTH), "queue occupancy above depth")
  `BPS_ASSERT_NOW(a_ptr_match, clk_i, rst_ni, (occ_q == '0) || full, head_q == tail_q, "head and tail disagree with occupancy")
  `BPS_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, ram_we, occ_q == $past(occ_q) + 1'b1, "accepted push did not grow the queue")
  `BPS_ASSERT_NOW(a_div_owned, clk_i, rst_ni, div_stat.busy || div_stat.done, state_q == ST_DIV, "divider active outside its state")

endmodule

`default_nettype wire
